// ===== sv/rfst_pkg.sv =====
// ----------------------------------------------------------------------------
// rfst_pkg
// Shared types and constants for the receive frame slot table.
// ----------------------------------------------------------------------------
package rfst_pkg;

	// Default number of slots in the table
	localparam int SLOT_COUNT_DEF = 16;

	// Operation codes
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_RELEASE = 2'd1,
		OP_FLUSH   = 2'd2
	} op_t;

	// One input transaction
	typedef struct packed {
		op_t         operation;
		logic [15:0] frame_handle;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic [3:0]  stored_slot;
		logic        dropped;
		logic        not_found;
		logic [4:0]  live_count;
		logic        head_valid;
		logic [15:0] head_handle;
	} result_t;

endpackage

// ===== sv/rfst_stream_if.sv =====
// ----------------------------------------------------------------------------
// rfst_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rfst_stream_if #(
	parameter type payload_t = rfst_pkg::item_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/rfst_table.sv =====
// ----------------------------------------------------------------------------
// rfst_table
// Slot storage with occupied and pending-free bits, plus the combinational
// operation logic that computes the next table state and the result.
// ----------------------------------------------------------------------------
module rfst_table #(
	parameter int SlotCount = rfst_pkg::SLOT_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  rfst_pkg::item_t  item,
	output rfst_pkg::result_t res
);

	logic [15:0]          handle_q [SlotCount];
	logic [SlotCount-1:0] occ_q;
	logic [SlotCount-1:0] pend_q;

	logic [SlotCount-1:0] occ_n;
	logic [SlotCount-1:0] pend_n;
	logic [SlotCount-1:0] occ_p;
	logic [SlotCount-1:0] free_v;
	logic [SlotCount-1:0] free_oh;
	logic [SlotCount-1:0] match_v;
	logic [SlotCount-1:0] match_oh;
	logic [SlotCount-1:0] hnd_wr;
	logic [SlotCount-1:0] live_v;
	logic [SlotCount-1:0] live_oh;
	logic [5:0]           free_idx;
	logic [6:0]           live_cnt;
	logic [15:0]          head_hnd;
	logic [3:0]           stored_c;
	logic                 drop_c;
	logic                 nf_c;

	// Compare all slots in parallel and pick the lowest free and matching slots
	always_comb begin
		occ_p    = occ_q & ~pend_q;
		free_v   = ~occ_p;
		free_oh  = free_v & (~free_v + 1'b1);
		match_v  = '0;
		free_idx = '0;
		for (int i = 0; i < SlotCount; i++) begin
			match_v[i] = occ_q[i] && (handle_q[i] == item.frame_handle);
			if (free_oh[i]) begin
				free_idx = free_idx | 6'(i);
			end
		end
		match_oh = match_v & (~match_v + 1'b1);
	end

	// Apply the operation to the occupancy and mark vectors
	always_comb begin
		occ_n    = occ_q;
		pend_n   = pend_q;
		hnd_wr   = '0;
		stored_c = '0;
		drop_c   = 1'b0;
		nf_c     = 1'b0;
		case (item.operation)
			rfst_pkg::OP_INSERT: begin
				pend_n = '0;
				if (|free_v) begin
					occ_n    = occ_p | free_oh;
					hnd_wr   = free_oh;
					stored_c = free_idx[3:0];
				end else begin
					occ_n  = occ_p;
					drop_c = 1'b1;
				end
			end
			rfst_pkg::OP_RELEASE: begin
				if (|match_v) begin
					pend_n = pend_q | match_oh;
				end else begin
					nf_c = 1'b1;
				end
			end
			rfst_pkg::OP_FLUSH: begin
				pend_n = '1;
			end
			default: begin
			end
		endcase
	end

	// Summarize the live entries after the operation
	always_comb begin
		live_v   = occ_n & ~pend_n;
		live_oh  = live_v & (~live_v + 1'b1);
		live_cnt = 7'($countones(live_v));
		head_hnd = '0;
		for (int i = 0; i < SlotCount; i++) begin
			if (live_oh[i]) begin
				head_hnd = head_hnd | (hnd_wr[i] ? item.frame_handle : handle_q[i]);
			end
		end
		res.stored_slot = stored_c;
		res.dropped     = drop_c;
		res.not_found   = nf_c;
		res.live_count  = live_cnt[4:0];
		res.head_valid  = |live_v;
		res.head_handle = head_hnd;
	end

	// Hold occupancy and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			pend_q <= '0;
		end else if (en) begin
			occ_q  <= occ_n;
			pend_q <= pend_n;
		end
	end

	// Write the inserted handle into its slot
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SlotCount; i++) begin
				if (hnd_wr[i]) begin
					handle_q[i] <= item.frame_handle;
				end
			end
		end
	end

endmodule

// ===== sv/receive_frame_slot_table_top.sv =====
// Each transaction passes the input register, then the result register, before its
// result is offered; a stalled result register holds the execute stage.
// Throughput: one transaction per cycle while the result side keeps ready high; the
// table update for each operation is computed combinationally between the two registers.
// Reset clears every occupied and pending-free bit; stored handles are undefined
// until written, and no slot is read before it has been written.
// ----------------------------------------------------------------------------
// receive_frame_slot_table_top
// Slot table for received-frame handles with deferred freeing.
// ----------------------------------------------------------------------------
module receive_frame_slot_table_top #(
	parameter int SLOT_COUNT = rfst_pkg::SLOT_COUNT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	rfst_stream_if.sink   item,
	rfst_stream_if.source result
);

	rfst_pkg::item_t   item_s1;
	logic              valid_s1;
	rfst_pkg::result_t res_c;
	rfst_pkg::result_t result_q;
	logic              valid_q;
	logic              advance;

	// Move the execute stage when the result register is free or draining
	assign advance    = !valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.payload;
		end
	end

	// Execute against the table
	rfst_table #(
		.SlotCount(SLOT_COUNT)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.item   (item_s1),
		.res    (res_c)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= res_c;
		end
	end

	assign result.valid   = valid_q;
	assign result.payload = result_q;

endmodule
